/* rtl/rhp_pkg.sv */
// rhp_pkg: types, codes and constants of the request header parser
// used by request_header_parser_fnv_check and tb_top
// no dependencies
package rhp_pkg;

    // one header byte as it arrives
    typedef struct packed {
        logic       start_req;
        logic [7:0] data_byte;
    } in_item_t;

    // one result: an address byte or the header summary
    typedef struct packed {
        logic        result_kind;
        logic [7:0]  address_byte;
        logic [7:0]  version;
        logic [7:0]  nonce;
        logic [7:0]  option;
        logic [3:0]  security;
        logic [7:0]  command;
        logic [15:0] port;
        logic [7:0]  address_type;
        logic [7:0]  address_length;
        logic [1:0]  status;
    } out_item_t;

    // parser phases, one-hot
    typedef enum logic [14:0] {
        PH_IDLE     = 15'b000_0000_0000_0001,
        PH_VERSION  = 15'b000_0000_0000_0010,
        PH_SKIP     = 15'b000_0000_0000_0100,
        PH_NONCE    = 15'b000_0000_0000_1000,
        PH_OPTION   = 15'b000_0000_0001_0000,
        PH_SECURITY = 15'b000_0000_0010_0000,
        PH_RESERVED = 15'b000_0000_0100_0000,
        PH_COMMAND  = 15'b000_0000_1000_0000,
        PH_PORT_HI  = 15'b000_0001_0000_0000,
        PH_PORT_LO  = 15'b000_0010_0000_0000,
        PH_ATYPE    = 15'b000_0100_0000_0000,
        PH_DLEN     = 15'b000_1000_0000_0000,
        PH_ADDR     = 15'b001_0000_0000_0000,
        PH_PAD      = 15'b010_0000_0000_0000,
        PH_CSUM     = 15'b100_0000_0000_0000
    } phase_t;

    localparam logic KIND_ADDR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH  = 2'd1;
    localparam logic [1:0] STATUS_BAD_ATYPE = 2'd2;

    localparam logic [7:0] ATYPE_IPV4   = 8'd1;
    localparam logic [7:0] ATYPE_DOMAIN = 8'd2;
    localparam logic [7:0] ATYPE_IPV6   = 8'd3;

    localparam logic [7:0] SKIP_LEN = 8'd32;  // iv check plus key check
    localparam logic [7:0] IPV4_LEN = 8'd4;
    localparam logic [7:0] IPV6_LEN = 8'd16;
    localparam logic [7:0] CSUM_LEN = 8'd4;

    localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;

    // one fnv-1a step; prime 16777619 = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 2^0
    function automatic logic [31:0] fnv1a_step(input logic [31:0] sum,
                                               input logic [7:0]  b);
        logic [31:0] mix;
        begin
            mix = sum ^ {24'd0, b};
            fnv1a_step = (mix << 24) + (mix << 8) + (mix << 7) + (mix << 4)
                       + (mix << 1) + mix;
        end
    endfunction

endpackage

/* rtl/rhp_stream_if.sv */
// rhp_stream_if: valid/ready channel carrying one payload per transaction
// payload type is set by the instantiating level (rhp_pkg item types)
// depends on nothing else
interface rhp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/request_header_parser_fnv_check.sv */
// request_header_parser_fnv_check: byte-wide request header parser with fnv-1a check
// depends on rhp_pkg and rhp_stream_if
// each result is registered in the output register when its byte is accepted
// throughput: one header byte per cycle; header ready drops only while a result waits
// reset: asynchronous, active low; the parser idles with the hash at its offset basis
// and the output register empty
module request_header_parser_fnv_check (
    input  logic        clk,
    input  logic        rst_n,
    rhp_stream_if.sink   header,
    rhp_stream_if.source result
);

    // parser state
    rhp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      count_reg, count_next;
    logic [31:0]     fnv_reg, fnv_next;
    logic [31:0]     csum_reg, csum_next;
    logic [7:0]      version_reg, version_next;
    logic [7:0]      nonce_reg, nonce_next;
    logic [7:0]      option_reg, option_next;
    logic [7:0]      security_reg, security_next;
    logic [7:0]      command_reg, command_next;
    logic [15:0]     port_reg, port_next;
    logic [7:0]      atype_reg, atype_next;
    logic [7:0]      alen_reg, alen_next;

    // state as seen by this byte (a start byte restarts the header)
    rhp_pkg::phase_t cur_phase;
    logic [7:0]      cur_count;
    logic [31:0]     cur_fnv;
    logic [31:0]     cur_csum;
    logic [7:0]      cur_version;
    logic [7:0]      cur_nonce;
    logic [7:0]      cur_option;
    logic [7:0]      cur_security;
    logic [7:0]      cur_command;
    logic [15:0]     cur_port;
    logic [7:0]      cur_atype;
    logic [7:0]      cur_alen;

    logic [7:0]      byte_in;
    logic [7:0]      count_inc;
    logic [3:0]      pad_len;
    logic [31:0]     fnv_hashed;
    logic            emit;
    logic            emit_kind;
    logic [1:0]      emit_status;
    rhp_pkg::out_item_t emit_item;

    // output register
    logic               out_valid_reg;
    rhp_pkg::out_item_t out_data_reg;

    logic in_fire;

    // a new byte is taken whenever the output register is free or drains now
    assign header.ready = !out_valid_reg || result.ready;
    assign in_fire      = header.valid && header.ready;

    assign byte_in = header.data.data_byte;

    always_comb
    begin
        cur_phase    = phase_reg;
        cur_count    = count_reg;
        cur_fnv      = fnv_reg;
        cur_csum     = csum_reg;
        cur_version  = version_reg;
        cur_nonce    = nonce_reg;
        cur_option   = option_reg;
        cur_security = security_reg;
        cur_command  = command_reg;
        cur_port     = port_reg;
        cur_atype    = atype_reg;
        cur_alen     = alen_reg;
        if (header.data.start_req)
        begin
            cur_phase    = rhp_pkg::PH_VERSION;
            cur_count    = 8'd0;
            cur_fnv      = rhp_pkg::FNV_BASIS;
            cur_csum     = 32'd0;
            cur_version  = 8'd0;
            cur_nonce    = 8'd0;
            cur_option   = 8'd0;
            cur_security = 8'd0;
            cur_command  = 8'd0;
            cur_port     = 16'd0;
            cur_atype    = 8'd0;
            cur_alen     = 8'd0;
        end
    end

    assign count_inc  = 8'(cur_count + 8'd1);
    assign pad_len    = cur_security[7:4];
    assign fnv_hashed = rhp_pkg::fnv1a_step(cur_fnv, byte_in);

    always_comb
    begin
        phase_next    = cur_phase;
        count_next    = cur_count;
        fnv_next      = cur_fnv;
        csum_next     = cur_csum;
        version_next  = cur_version;
        nonce_next    = cur_nonce;
        option_next   = cur_option;
        security_next = cur_security;
        command_next  = cur_command;
        port_next     = cur_port;
        atype_next    = cur_atype;
        alen_next     = cur_alen;
        emit          = 1'b0;
        emit_kind     = rhp_pkg::KIND_SUMMARY;
        emit_status   = rhp_pkg::STATUS_OK;

        // hash covers every header byte up to the checksum
        if (cur_phase != rhp_pkg::PH_IDLE && cur_phase != rhp_pkg::PH_CSUM)
        begin
            fnv_next = fnv_hashed;
        end

        unique case (cur_phase)
            rhp_pkg::PH_IDLE:
            begin
                // stray byte, dropped
            end
            rhp_pkg::PH_VERSION:
            begin
                version_next = byte_in;
                count_next   = 8'd0;
                phase_next   = rhp_pkg::PH_SKIP;
            end
            rhp_pkg::PH_SKIP:
            begin
                count_next = count_inc;
                if (count_inc >= rhp_pkg::SKIP_LEN)
                begin
                    count_next = 8'd0;
                    phase_next = rhp_pkg::PH_NONCE;
                end
            end
            rhp_pkg::PH_NONCE:
            begin
                nonce_next = byte_in;
                phase_next = rhp_pkg::PH_OPTION;
            end
            rhp_pkg::PH_OPTION:
            begin
                option_next = byte_in;
                phase_next  = rhp_pkg::PH_SECURITY;
            end
            rhp_pkg::PH_SECURITY:
            begin
                security_next = byte_in;
                phase_next    = rhp_pkg::PH_RESERVED;
            end
            rhp_pkg::PH_RESERVED:
            begin
                phase_next = rhp_pkg::PH_COMMAND;
            end
            rhp_pkg::PH_COMMAND:
            begin
                command_next = byte_in;
                phase_next   = rhp_pkg::PH_PORT_HI;
            end
            rhp_pkg::PH_PORT_HI:
            begin
                port_next  = {byte_in, 8'd0};
                phase_next = rhp_pkg::PH_PORT_LO;
            end
            rhp_pkg::PH_PORT_LO:
            begin
                port_next  = {cur_port[15:8], byte_in};
                phase_next = rhp_pkg::PH_ATYPE;
            end
            rhp_pkg::PH_ATYPE:
            begin
                atype_next = byte_in;
                count_next = 8'd0;
                if (byte_in == rhp_pkg::ATYPE_IPV4)
                begin
                    alen_next  = rhp_pkg::IPV4_LEN;
                    phase_next = rhp_pkg::PH_ADDR;
                end
                else if (byte_in == rhp_pkg::ATYPE_DOMAIN)
                begin
                    phase_next = rhp_pkg::PH_DLEN;
                end
                else if (byte_in == rhp_pkg::ATYPE_IPV6)
                begin
                    alen_next  = rhp_pkg::IPV6_LEN;
                    phase_next = rhp_pkg::PH_ADDR;
                end
                else
                begin
                    // unknown address type ends the header at once
                    alen_next   = 8'd0;
                    emit        = 1'b1;
                    emit_status = rhp_pkg::STATUS_BAD_ATYPE;
                    phase_next  = rhp_pkg::PH_IDLE;
                end
            end
            rhp_pkg::PH_DLEN:
            begin
                alen_next  = byte_in;
                count_next = 8'd0;
                if (byte_in == 8'd0)
                begin
                    // empty domain
                    phase_next = (pad_len != 4'd0) ? rhp_pkg::PH_PAD : rhp_pkg::PH_CSUM;
                end
                else
                begin
                    phase_next = rhp_pkg::PH_ADDR;
                end
            end
            rhp_pkg::PH_ADDR:
            begin
                emit       = 1'b1;
                emit_kind  = rhp_pkg::KIND_ADDR;
                count_next = count_inc;
                if (count_inc >= cur_alen)
                begin
                    count_next = 8'd0;
                    phase_next = (pad_len != 4'd0) ? rhp_pkg::PH_PAD : rhp_pkg::PH_CSUM;
                end
            end
            rhp_pkg::PH_PAD:
            begin
                count_next = count_inc;
                if (count_inc >= {4'd0, pad_len})
                begin
                    count_next = 8'd0;
                    phase_next = rhp_pkg::PH_CSUM;
                end
            end
            rhp_pkg::PH_CSUM:
            begin
                // big-endian checksum shifts in from the low end
                csum_next  = {cur_csum[23:0], byte_in};
                count_next = count_inc;
                if (count_inc >= rhp_pkg::CSUM_LEN)
                begin
                    emit        = 1'b1;
                    emit_status = ({cur_csum[23:0], byte_in} == cur_fnv) ?
                                  rhp_pkg::STATUS_OK : rhp_pkg::STATUS_MISMATCH;
                    phase_next  = rhp_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = rhp_pkg::PH_IDLE;
            end
        endcase
    end

    // result payload: an address byte carries zeros in the summary fields
    always_comb
    begin
        emit_item = '0;
        emit_item.result_kind = emit_kind;
        if (emit_kind == rhp_pkg::KIND_ADDR)
        begin
            emit_item.address_byte = byte_in;
        end
        else
        begin
            emit_item.version        = version_next;
            emit_item.nonce          = nonce_next;
            emit_item.option         = option_next;
            emit_item.security       = security_next[3:0];
            emit_item.command        = command_next;
            emit_item.port           = port_next;
            emit_item.address_type   = atype_next;
            emit_item.address_length = alen_next;
            emit_item.status         = emit_status;
        end
    end

    // parser state advances once per accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= rhp_pkg::PH_IDLE;
            count_reg    <= 8'd0;
            fnv_reg      <= rhp_pkg::FNV_BASIS;
            csum_reg     <= 32'd0;
            version_reg  <= 8'd0;
            nonce_reg    <= 8'd0;
            option_reg   <= 8'd0;
            security_reg <= 8'd0;
            command_reg  <= 8'd0;
            port_reg     <= 16'd0;
            atype_reg    <= 8'd0;
            alen_reg     <= 8'd0;
        end
        else if (in_fire)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            fnv_reg      <= fnv_next;
            csum_reg     <= csum_next;
            version_reg  <= version_next;
            nonce_reg    <= nonce_next;
            option_reg   <= option_next;
            security_reg <= security_next;
            command_reg  <= command_next;
            port_reg     <= port_next;
            atype_reg    <= atype_next;
            alen_reg     <= alen_next;
        end
    end

    // output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            out_data_reg <= emit_item;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // a summary always leaves the parser idle
    a_summary_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && emit && emit_kind == rhp_pkg::KIND_SUMMARY
        |=> phase_reg == rhp_pkg::PH_IDLE)
        else $error("parser not idle after summary");

    // a bad address type summary reports no address bytes
    a_bad_atype_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.result_kind == rhp_pkg::KIND_SUMMARY
        && out_data_reg.status == rhp_pkg::STATUS_BAD_ATYPE
        |-> out_data_reg.address_length == 8'd0)
        else $error("bad address type summary with nonzero length");

    // address byte results carry no summary content
    a_addr_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.result_kind == rhp_pkg::KIND_ADDR
        |-> out_data_reg.status == rhp_pkg::STATUS_OK && out_data_reg.port == 16'd0
            && out_data_reg.address_length == 8'd0)
        else $error("address byte result with summary fields set");

    // the skip counter never reaches the end of the check bytes while skipping
    a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == rhp_pkg::PH_SKIP |-> count_reg < rhp_pkg::SKIP_LEN)
        else $error("skip counter out of range");

    // a waiting result that is not taken stays in the output register unchanged
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result dropped or overwritten");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for request_header_parser_fnv_check
// drives header bytes, predicts address bytes and header summaries, checks each result
// depends on rhp_pkg, rhp_stream_if and the parser rtl
module tb_top;

    localparam logic [31:0] FNV_PRIME     = 32'd16777619;
    localparam int          RANDOM_BYTES  = 450;
    localparam int          SETTLE_CYCLES = 16;

    logic clk;
    logic rst_n;

    rhp_stream_if #(.payload_t(rhp_pkg::in_item_t))  header_if ();
    rhp_stream_if #(.payload_t(rhp_pkg::out_item_t)) result_if ();

    request_header_parser_fnv_check i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .header (header_if),
        .result (result_if)
    );

    // parser mirror: phase, counters, running hash and the header fields seen so far
    rhp_pkg::phase_t parse_phase;
    logic [7:0]  byte_count;
    logic [31:0] running_hash;
    logic [31:0] rx_checksum;
    logic [7:0]  hdr_version;
    logic [7:0]  hdr_nonce;
    logic [7:0]  hdr_option;
    logic [7:0]  hdr_security;
    logic [7:0]  hdr_command;
    logic [15:0] hdr_port;
    logic [7:0]  hdr_atype;
    logic [7:0]  hdr_addr_len;

    // results still owed by the parser, oldest first
    rhp_pkg::out_item_t expected_results[$];
    // bytes of the header currently being sent
    logic [7:0]  header_bytes[$];

    int          mismatch_count = 0;
    int          consumed_bytes = 0;   // bytes the parser actually took in
    int          burst_left     = 0;

    // free-running clock, 8 ns period
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop in case the handshake hangs
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // one fnv-1a round
    function automatic logic [31:0] fnv_mix(input logic [31:0] sum, input logic [7:0] b);
        return (sum ^ {24'd0, b}) * FNV_PRIME;
    endfunction

    // everything a start byte throws away
    task automatic clear_parsed_header();
        byte_count   = '0;
        running_hash = rhp_pkg::FNV_BASIS;
        rx_checksum  = '0;
        hdr_version  = '0;
        hdr_nonce    = '0;
        hdr_option   = '0;
        hdr_security = '0;
        hdr_command  = '0;
        hdr_port     = '0;
        hdr_atype    = '0;
        hdr_addr_len = '0;
    endtask

    function automatic rhp_pkg::out_item_t header_summary(input logic [1:0] st);
        rhp_pkg::out_item_t s;
        s                = '0;
        s.result_kind    = rhp_pkg::KIND_SUMMARY;
        s.version        = hdr_version;
        s.nonce          = hdr_nonce;
        s.option         = hdr_option;
        s.security       = hdr_security[3:0];
        s.command        = hdr_command;
        s.port           = hdr_port;
        s.address_type   = hdr_atype;
        s.address_length = hdr_addr_len;
        s.status         = st;
        return s;
    endfunction

    // after the last address byte: padding if the high nibble asks for it, else checksum
    task automatic finish_address();
        byte_count  = '0;
        parse_phase = (hdr_security[7:4] != 4'd0) ? rhp_pkg::PH_PAD : rhp_pkg::PH_CSUM;
    endtask

    // advance the mirror by one accepted byte and queue whatever result it causes
    task automatic predict_header_byte(input rhp_pkg::in_item_t item);
        rhp_pkg::out_item_t addr_res;
        logic [7:0]         b;
        b = item.data_byte;
        if (item.start_req)
        begin
            clear_parsed_header();
            parse_phase = rhp_pkg::PH_VERSION;
        end
        // idle and no start: byte is dropped
        if (parse_phase == rhp_pkg::PH_IDLE)
            return;
        consumed_bytes++;
        // checksum bytes are not part of the hash
        if (parse_phase != rhp_pkg::PH_CSUM)
            running_hash = fnv_mix(running_hash, b);
        case (parse_phase)
            rhp_pkg::PH_VERSION:
            begin
                hdr_version = b;
                byte_count  = '0;
                parse_phase = rhp_pkg::PH_SKIP;
            end
            rhp_pkg::PH_SKIP:
            begin
                // iv check and key check are hashed but not kept
                byte_count++;
                if (byte_count >= rhp_pkg::SKIP_LEN)
                begin
                    byte_count  = '0;
                    parse_phase = rhp_pkg::PH_NONCE;
                end
            end
            rhp_pkg::PH_NONCE:
            begin
                hdr_nonce   = b;
                parse_phase = rhp_pkg::PH_OPTION;
            end
            rhp_pkg::PH_OPTION:
            begin
                hdr_option  = b;
                parse_phase = rhp_pkg::PH_SECURITY;
            end
            rhp_pkg::PH_SECURITY:
            begin
                hdr_security = b;
                parse_phase  = rhp_pkg::PH_RESERVED;
            end
            rhp_pkg::PH_RESERVED:
                parse_phase = rhp_pkg::PH_COMMAND;
            rhp_pkg::PH_COMMAND:
            begin
                hdr_command = b;
                parse_phase = rhp_pkg::PH_PORT_HI;
            end
            rhp_pkg::PH_PORT_HI:
            begin
                hdr_port    = {b, 8'd0};
                parse_phase = rhp_pkg::PH_PORT_LO;
            end
            rhp_pkg::PH_PORT_LO:
            begin
                hdr_port    = {hdr_port[15:8], b};
                parse_phase = rhp_pkg::PH_ATYPE;
            end
            rhp_pkg::PH_ATYPE:
            begin
                hdr_atype  = b;
                byte_count = '0;
                if (b == rhp_pkg::ATYPE_IPV4)
                begin
                    hdr_addr_len = rhp_pkg::IPV4_LEN;
                    parse_phase  = rhp_pkg::PH_ADDR;
                end
                else if (b == rhp_pkg::ATYPE_DOMAIN)
                    parse_phase = rhp_pkg::PH_DLEN;
                else if (b == rhp_pkg::ATYPE_IPV6)
                begin
                    hdr_addr_len = rhp_pkg::IPV6_LEN;
                    parse_phase  = rhp_pkg::PH_ADDR;
                end
                else
                begin
                    // unknown address type: summary right away, header abandoned
                    hdr_addr_len = '0;
                    expected_results.push_back(header_summary(rhp_pkg::STATUS_BAD_ATYPE));
                    parse_phase = rhp_pkg::PH_IDLE;
                end
            end
            rhp_pkg::PH_DLEN:
            begin
                // the length byte itself is never emitted
                hdr_addr_len = b;
                byte_count   = '0;
                if (b == 8'd0)
                    finish_address();
                else
                    parse_phase = rhp_pkg::PH_ADDR;
            end
            rhp_pkg::PH_ADDR:
            begin
                addr_res              = '0;
                addr_res.result_kind  = rhp_pkg::KIND_ADDR;
                addr_res.address_byte = b;
                expected_results.push_back(addr_res);
                byte_count++;
                if (byte_count >= hdr_addr_len)
                    finish_address();
            end
            rhp_pkg::PH_PAD:
            begin
                byte_count++;
                if (byte_count >= {4'd0, hdr_security[7:4]})
                begin
                    byte_count  = '0;
                    parse_phase = rhp_pkg::PH_CSUM;
                end
            end
            rhp_pkg::PH_CSUM:
            begin
                // big-endian checksum shifts in from the low end
                rx_checksum = {rx_checksum[23:0], b};
                byte_count++;
                if (byte_count >= rhp_pkg::CSUM_LEN)
                begin
                    expected_results.push_back(header_summary(
                        (rx_checksum == running_hash) ? rhp_pkg::STATUS_OK
                                                      : rhp_pkg::STATUS_MISMATCH));
                    parse_phase = rhp_pkg::PH_IDLE;
                end
            end
            default:
                parse_phase = rhp_pkg::PH_IDLE;
        endcase
    endtask

    // one header byte through the handshake; the sender goes in bursts with random gaps
    task automatic send_byte(input logic start, input logic [7:0] b);
        rhp_pkg::in_item_t item;
        int                gap;
        item.start_req = start;
        item.data_byte = b;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            header_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        header_if.valid <= 1'b1;
        header_if.data  <= item;
        do
            @(posedge clk);
        while (!header_if.ready);
        predict_header_byte(item);
    endtask

    // hold the sender off until the parser has delivered everything owed
    task automatic wait_for_results();
        header_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // assemble a header: skip region, reserved and address bytes are random,
    // checksum is correct or has one bit flipped
    task automatic build_header(input logic [7:0] ver, nonce, opt, sec, cmd,
                                input logic [15:0] port_num, input logic [7:0] atype,
                                input int dom_len, input bit csum_ok);
        logic [31:0] sum;
        header_bytes.delete();
        header_bytes.push_back(ver);
        repeat (rhp_pkg::SKIP_LEN) header_bytes.push_back(8'($urandom));
        header_bytes.push_back(nonce);
        header_bytes.push_back(opt);
        header_bytes.push_back(sec);
        header_bytes.push_back(8'($urandom));
        header_bytes.push_back(cmd);
        header_bytes.push_back(port_num[15:8]);
        header_bytes.push_back(port_num[7:0]);
        header_bytes.push_back(atype);
        if (atype == rhp_pkg::ATYPE_IPV4)
            repeat (rhp_pkg::IPV4_LEN) header_bytes.push_back(8'($urandom));
        else if (atype == rhp_pkg::ATYPE_IPV6)
            repeat (rhp_pkg::IPV6_LEN) header_bytes.push_back(8'($urandom));
        else if (atype == rhp_pkg::ATYPE_DOMAIN)
        begin
            header_bytes.push_back(dom_len[7:0]);
            repeat (dom_len) header_bytes.push_back(8'($urandom));
        end
        else
            return;   // parser stops at a bad type, nothing more to send
        repeat (sec[7:4]) header_bytes.push_back(8'($urandom));
        sum = rhp_pkg::FNV_BASIS;
        foreach (header_bytes[i])
            sum = fnv_mix(sum, header_bytes[i]);
        if (!csum_ok)
            sum ^= 32'd1 << $urandom_range(0, 31);
        header_bytes.push_back(sum[31:24]);
        header_bytes.push_back(sum[23:16]);
        header_bytes.push_back(sum[15:8]);
        header_bytes.push_back(sum[7:0]);
    endtask

    // first byte carries the start flag; count below the size cuts the header short
    task automatic send_header_bytes(input int count);
        for (int i = 0; i < count; i++)
            send_byte(i == 0, header_bytes[i]);
    endtask

    task automatic send_random_header(input bit truncate);
        logic [7:0] atype;
        logic [7:0] sec;
        logic [3:0] pad;
        int         dom_len;
        int         pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            atype = rhp_pkg::ATYPE_IPV4;
        else if (pick < 5)
            atype = rhp_pkg::ATYPE_IPV6;
        else if (pick < 9)
            atype = rhp_pkg::ATYPE_DOMAIN;
        else
            atype = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(4, 255)) : 8'd0;
        // mostly short padding, now and then anything up to fifteen
        pad     = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 2));
        sec     = {pad, 4'($urandom)};
        dom_len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 255)
                                               : $urandom_range(0, 12);
        build_header(8'($urandom), 8'($urandom), 8'($urandom), sec, 8'($urandom),
                     16'($urandom), atype, dom_len, $urandom_range(0, 3) != 0);
        send_header_bytes(truncate ? $urandom_range(1, header_bytes.size() - 1)
                                   : header_bytes.size());
    endtask

    // bytes without start while idle must be dropped silently
    task automatic test_idle_bytes();
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hff);
        send_byte(1'b0, 8'h5a);
        wait_for_results();
    endtask

    // ipv4, no padding, all-ones port and command
    task automatic test_ipv4_header();
        build_header(8'h00, 8'hff, 8'h00, 8'h05, 8'hff, 16'hffff, rhp_pkg::ATYPE_IPV4, 0,
                     1'b1);
        send_header_bytes(header_bytes.size());
        wait_for_results();
    endtask

    // domain with the longest padding and a full security nibble
    task automatic test_domain_padding();
        build_header(8'hff, 8'h00, 8'hff, 8'hff, 8'h00, 16'h0000, rhp_pkg::ATYPE_DOMAIN, 5,
                     1'b1);
        send_header_bytes(header_bytes.size());
        wait_for_results();
    endtask

    // zero-length domain goes straight to padding
    task automatic test_empty_domain();
        build_header(8'h01, 8'h12, 8'h34, 8'h30, 8'h01, 16'h1f90, rhp_pkg::ATYPE_DOMAIN, 0,
                     1'b1);
        send_header_bytes(header_bytes.size());
        wait_for_results();
    endtask

    // longest domain name the length byte allows
    task automatic test_longest_domain();
        build_header(8'h01, 8'haa, 8'h55, 8'h10, 8'h02, 16'h8000, rhp_pkg::ATYPE_DOMAIN, 255,
                     1'b1);
        send_header_bytes(header_bytes.size());
        wait_for_results();
    endtask

    // ipv6 with a corrupted checksum
    task automatic test_ipv6_mismatch();
        build_header(8'h01, 8'h77, 8'h01, 8'h23, 8'h03, 16'h0050, rhp_pkg::ATYPE_IPV6, 0,
                     1'b0);
        send_header_bytes(header_bytes.size());
        wait_for_results();
    endtask

    // unknown address types at both ends of the byte range and just past ipv6
    task automatic test_bad_address_type();
        build_header(8'h01, 8'h01, 8'h02, 8'h03, 8'h04, 16'h0102, 8'd0, 0, 1'b1);
        send_header_bytes(header_bytes.size());
        build_header(8'h02, 8'h05, 8'h06, 8'hf7, 8'h08, 16'h0304, 8'd255, 0, 1'b1);
        send_header_bytes(header_bytes.size());
        build_header(8'h03, 8'h09, 8'h0a, 8'h0b, 8'h0c, 16'h0506, 8'd4, 0, 1'b1);
        send_header_bytes(header_bytes.size());
        wait_for_results();
    endtask

    // start arriving in the skip region and again in the middle of an address
    task automatic test_restart_mid_header();
        build_header(8'h01, 8'h11, 8'h22, 8'h00, 8'h01, 16'h0016, rhp_pkg::ATYPE_IPV4, 0,
                     1'b1);
        send_header_bytes(10);
        build_header(8'h01, 8'h33, 8'h44, 8'h20, 8'h01, 16'h01bb, rhp_pkg::ATYPE_IPV4, 0,
                     1'b1);
        send_header_bytes(43);
        build_header(8'h01, 8'h55, 8'h66, 8'h0a, 8'h01, 16'h0035, rhp_pkg::ATYPE_IPV6, 0,
                     1'b1);
        send_header_bytes(header_bytes.size());
        wait_for_results();
    endtask

    // mostly complete headers, some cut short, some stray bytes, now and then a full drain
    task automatic test_random_traffic();
        int target;
        int pick;
        target = consumed_bytes + RANDOM_BYTES;
        while (consumed_bytes < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                send_random_header(1'b0);
            else if (pick < 90)
                send_random_header(1'b1);
            else if (pick < 96)
                repeat ($urandom_range(1, 6)) send_byte(1'b0, 8'($urandom));
            else
                wait_for_results();
        end
    endtask

    // result side: ready follows a rotating random stall pattern, replaced when its run ends
    initial
    begin
        logic [31:0] ready_pattern;
        int          pattern_left;
        ready_pattern = '1;
        pattern_left  = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pattern_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = '1;                               // no stalls
                    1:       ready_pattern = $urandom | 32'h0001_0001;
                    2:       ready_pattern = ($urandom & $urandom) | 32'h0001_0001;
                    default: ready_pattern = $urandom | $urandom;
                endcase
                pattern_left = $urandom_range(16, 96);
            end
            result_if.ready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
            pattern_left--;
        end
    end

    // every result transaction against the oldest expectation
    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        rhp_pkg::out_item_t want;
        rhp_pkg::out_item_t got;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got = result_if.data;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d byte 0x%0h",
                         $time, got.result_kind, got.address_byte);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
                check_field("address_byte", 32'(want.address_byte), 32'(got.address_byte));
                check_field("version", 32'(want.version), 32'(got.version));
                check_field("nonce", 32'(want.nonce), 32'(got.nonce));
                check_field("option", 32'(want.option), 32'(got.option));
                check_field("security", 32'(want.security), 32'(got.security));
                check_field("command", 32'(want.command), 32'(got.command));
                check_field("port", 32'(want.port), 32'(got.port));
                check_field("address_type", 32'(want.address_type), 32'(got.address_type));
                check_field("address_length", 32'(want.address_length),
                            32'(got.address_length));
                check_field("status", 32'(want.status), 32'(got.status));
            end
        end
    end

    // reset, directed cases, random traffic, drain, verdict
    initial
    begin
        parse_phase = rhp_pkg::PH_IDLE;
        clear_parsed_header();
        rst_n           <= 1'b0;
        header_if.valid <= 1'b0;
        header_if.data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_bytes();
        test_ipv4_header();
        test_domain_padding();
        test_empty_domain();
        test_ipv6_mismatch();
        test_bad_address_type();
        test_restart_mid_header();
        test_longest_domain();
        test_random_traffic();

        wait_for_results();
        // let any late or spurious result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
